@@ rtl/srgb_lcc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_lcc_pkg - shared types, constants and curve builders
// Pixel and result payload types, pipeline control bundle, fixed-point
// constants of the sRGB transfer function, and the constant functions that
// build the interpolation curve points at elaboration.
// ----------------------------------------------------------------------------
package srgb_lcc_pkg;

	localparam int COMPONENT_BITS     = 16;
	localparam int CURVE_SEGMENTS_DEF = 256;
	localparam int NUM_STAGES         = 6;

	// Q30 working format, values in [0, 2^30]
	localparam int Q_FRAC   = 30;
	localparam int Y_W      = Q_FRAC + 1;
	localparam int LOG_FRAC = 20;

	localparam logic [COMPONENT_BITS-1:0] COMP_MAX = '1;
	localparam logic [Y_W-1:0]            Q_ONE    = {1'b1, {Q_FRAC{1'b0}}};
	localparam logic [Y_W-1:0]            LIN_KNEE  = 31'd43432857;
	localparam logic [Y_W-1:0]            SRGB_KNEE = 31'd3361671;

	localparam logic [63:0] Q_ONE64  = 64'd1 << Q_FRAC;
	localparam logic [63:0] K_OFFSET = 64'd59055800;
	localparam logic [63:0] K_SCALE  = Q_ONE64 + K_OFFSET;

	// component -> Q30: reciprocal of COMP_MAX scaled by 2^(COMPONENT_BITS+30)
	localparam int X_RECIP_W = Y_W;
	localparam logic [63:0] X_RECIP_FULL =
		(64'd1 << (COMPONENT_BITS + Q_FRAC)) / 64'(COMP_MAX);
	localparam logic [X_RECIP_W-1:0] X_RECIP = X_RECIP_FULL[X_RECIP_W-1:0];

	// Linear segments: toward linear floor((25x+161)/323),
	// toward sRGB floor((646x+25)/50); division by reciprocal over 2^32
	localparam int NUM_W   = 32;
	localparam int RECIP_W = 27;
	localparam int DIV_W   = 9;
	localparam logic [NUM_W-1:0] LIN_MUL  = 32'd25;
	localparam logic [NUM_W-1:0] LIN_ADD  = 32'd161;
	localparam logic [NUM_W-1:0] SRGB_MUL = 32'd646;
	localparam logic [NUM_W-1:0] SRGB_ADD = 32'd25;
	localparam logic [DIV_W-1:0] LIN_DIV  = 9'd323;
	localparam logic [DIV_W-1:0] SRGB_DIV = 9'd50;
	localparam logic [63:0] LIN_RECIP_FULL  = (64'd1 << NUM_W) / 64'd323;
	localparam logic [63:0] SRGB_RECIP_FULL = (64'd1 << NUM_W) / 64'd50;
	localparam logic [RECIP_W-1:0] LIN_RECIP  = LIN_RECIP_FULL[RECIP_W-1:0];
	localparam logic [RECIP_W-1:0] SRGB_RECIP = SRGB_RECIP_FULL[RECIP_W-1:0];

	typedef enum logic {
		DIR_TO_LINEAR = 1'b0,
		DIR_TO_SRGB   = 1'b1
	} dir_t;

	typedef logic [COMPONENT_BITS-1:0] comp_t;

	typedef struct packed {
		logic  cmd;
		comp_t red_in;
		comp_t green_in;
		comp_t blue_in;
		comp_t alpha_in;
	} pixel_t;

	typedef struct packed {
		comp_t red_out;
		comp_t green_out;
		comp_t blue_out;
		comp_t alpha_out;
	} result_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctrl_t;

	// ---- elaboration-time curve construction (64-bit exact) ----

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] rest;
		r = 64'd0;
		b = 64'd1 << 62;
		rest = v;
		while (b > rest) b = b >> 2;
		while (b != 64'd0) begin
			if (rest >= r + b) begin
				rest = rest - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// -log2(x) in Q20 for x in (0, 2^30]
	function automatic logic [63:0] neg_log2(input logic [63:0] x);
		logic [63:0] e;
		logic [63:0] frac;
		logic [63:0] m;
		e = 64'd0;
		frac = 64'd0;
		m = x;
		while (m < Q_ONE64) begin
			m = m << 1;
			e = e + 64'd1;
		end
		for (int k = 1; k <= LOG_FRAC; k++) begin
			m = (m * m) >> Q_FRAC;
			if (m >= 2 * Q_ONE64) begin
				m = m >> 1;
				frac = frac | (64'd1 << (LOG_FRAC - k));
			end
		end
		return (e << LOG_FRAC) - frac;
	endfunction

	// 2^(-L/2^20) in Q30
	function automatic logic [63:0] exp2_neg(input logic [63:0] l);
		logic [63:0] n;
		logic [63:0] f;
		logic [63:0] g;
		logic [63:0] r;
		logic [63:0] root;
		n = l >> LOG_FRAC;
		f = l & ((64'd1 << LOG_FRAC) - 64'd1);
		r = Q_ONE64;
		root = 2 * Q_ONE64;
		g = (64'd1 << LOG_FRAC) - f;
		if (f == 64'd0) begin
			return (n < 64'd40) ? (Q_ONE64 >> n) : 64'd0;
		end
		for (int k = 1; k <= LOG_FRAC; k++) begin
			root = isqrt64(root << Q_FRAC);
			if (((g >> (LOG_FRAC - k)) & 64'd1) != 64'd0) r = (r * root) >> Q_FRAC;
		end
		return ((n + 64'd1) < 64'd40) ? (r >> (n + 64'd1)) : 64'd0;
	endfunction

	function automatic logic [63:0] pow_12_5(input logic [63:0] x);
		logic [63:0] l;
		if (x == 64'd0) return 64'd0;
		if (x >= Q_ONE64) return Q_ONE64;
		l = (neg_log2(x) * 64'd12 + 64'd2) / 64'd5;
		return exp2_neg(l);
	endfunction

	function automatic logic [63:0] pow_5_12(input logic [63:0] x);
		logic [63:0] l;
		if (x == 64'd0) return 64'd0;
		if (x >= Q_ONE64) return Q_ONE64;
		l = (neg_log2(x) * 64'd5 + 64'd6) / 64'd12;
		return exp2_neg(l);
	endfunction

	// toward-linear curve point at Q30 abscissa xi
	function automatic logic [Y_W-1:0] lin_point(input logic [63:0] xi);
		logic [63:0] t;
		logic [63:0] p;
		t = ((xi + K_OFFSET) << Q_FRAC) / K_SCALE;
		p = pow_12_5(t);
		return p[Y_W-1:0];
	endfunction

	// toward-sRGB curve point at Q30 abscissa xi, floored at zero
	function automatic logic [Y_W-1:0] srgb_point(input logic [63:0] xi);
		logic [63:0] s;
		logic [63:0] d;
		s = (pow_5_12(xi) * K_SCALE) >> Q_FRAC;
		d = (s > K_OFFSET) ? (s - K_OFFSET) : 64'd0;
		return d[Y_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/srgb_lcc_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_lcc_lane - one color component through the sRGB transfer function
// Six-stage pipeline: Q30 scaling, exact correction, segment select and
// linear-branch divide, table read, interpolation, conversion back.
// ----------------------------------------------------------------------------
module srgb_lcc_lane
	import srgb_lcc_pkg::*;
#(
	parameter int CURVE_SEGMENTS = CURVE_SEGMENTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pipe_ctrl_t ctrl,
	input  logic       cmd,
	input  comp_t      comp,
	output comp_t      conv
);

	localparam int IDX_W  = $clog2(CURVE_SEGMENTS + 1);
	localparam int POS_W  = Y_W + IDX_W;
	localparam int P1_W   = COMPONENT_BITS + X_RECIP_W;
	localparam int XREM_W = COMPONENT_BITS + 2;
	localparam int DP_W   = NUM_W + RECIP_W;
	localparam int DREM_W = DIV_W + 2;
	localparam int IP_W   = 2 * Y_W;
	localparam int OW     = Y_W + COMPONENT_BITS + 1;
	localparam int OQ_W   = OW - Q_FRAC;

	// curve points, constant
	logic [Y_W-1:0] lin_tab  [CURVE_SEGMENTS+1];
	logic [Y_W-1:0] srgb_tab [CURVE_SEGMENTS+1];

	for (genvar i = 0; i <= CURVE_SEGMENTS; i++) begin : g_tab
		localparam logic [63:0] XI = (64'(i) << Q_FRAC) / 64'(CURVE_SEGMENTS);
		localparam logic [Y_W-1:0] LIN_P  = lin_point(XI);
		localparam logic [Y_W-1:0] SRGB_P = srgb_point(XI);
		assign lin_tab[i]  = LIN_P;
		assign srgb_tab[i] = SRGB_P;
	end

	// stage 1: component times reciprocal of full scale
	logic [P1_W-1:0] prod_s1;
	comp_t           comp_s1;
	logic            cmd_s1;

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			prod_s1 <= P1_W'(comp) * P1_W'(X_RECIP);
			comp_s1 <= comp;
			cmd_s1  <= cmd;
		end
	end

	// stage 2: exact floor(v * 2^30 / COMP_MAX)
	logic [Y_W-1:0]    x_est;
	logic [XREM_W-1:0] x_rem;
	logic [Y_W-1:0]    x_s2;
	logic              cmd_s2;

	always_comb begin
		x_est = prod_s1[P1_W-1:COMPONENT_BITS];
		x_rem = XREM_W'({comp_s1, {Q_FRAC{1'b0}}})
			- XREM_W'({x_est, {COMPONENT_BITS{1'b0}}}) + XREM_W'(x_est);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			x_s2   <= x_est + Y_W'(x_rem >= XREM_W'(COMP_MAX));
			cmd_s2 <= cmd_s1;
		end
	end

	// stage 3: segment position, knee test, linear-branch reciprocal product
	logic [POS_W-1:0]   pos;
	logic [IDX_W:0]     idx_raw;
	logic               pos_top;
	logic               to_srgb_s2;
	logic [NUM_W-1:0]   numer;
	logic [RECIP_W-1:0] recip;

	logic [IDX_W-1:0]   idx_s3;
	logic [Y_W-1:0]     frac_s3;
	logic               knee_s3;
	logic [NUM_W-1:0]   numer_s3;
	logic [DP_W-1:0]    dprod_s3;
	logic               cmd_s3;

	always_comb begin
		pos        = POS_W'(x_s2) * POS_W'(CURVE_SEGMENTS);
		idx_raw    = pos[POS_W-1:Q_FRAC];
		pos_top    = idx_raw >= (IDX_W + 1)'(CURVE_SEGMENTS);
		to_srgb_s2 = cmd_s2 == DIR_TO_SRGB;
		numer      = to_srgb_s2 ? (NUM_W'(x_s2) * SRGB_MUL + SRGB_ADD)
			: (NUM_W'(x_s2) * LIN_MUL + LIN_ADD);
		recip      = to_srgb_s2 ? SRGB_RECIP : LIN_RECIP;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			// full scale lands on the last segment at full weight
			idx_s3   <= pos_top ? IDX_W'(CURVE_SEGMENTS - 1) : idx_raw[IDX_W-1:0];
			frac_s3  <= pos_top ? Q_ONE : {1'b0, pos[Q_FRAC-1:0]};
			knee_s3  <= to_srgb_s2 ? (x_s2 <= SRGB_KNEE) : (x_s2 <= LIN_KNEE);
			numer_s3 <= numer;
			dprod_s3 <= DP_W'(numer) * DP_W'(recip);
			cmd_s3   <= cmd_s2;
		end
	end

	// stage 4: divide correction and curve point read
	logic [RECIP_W-1:0] d_est;
	logic [DIV_W-1:0]   divisor;
	logic [DREM_W-1:0]  d_rem;
	logic [IDX_W-1:0]   idx_nx;
	logic [Y_W-1:0]     pt_a;
	logic [Y_W-1:0]     pt_b;

	logic [Y_W-1:0]     a_s4;
	logic [Y_W-1:0]     diff_s4;
	logic               up_s4;
	logic [Y_W-1:0]     frac_s4;
	logic               knee_s4;
	logic [RECIP_W-1:0] liny_s4;

	always_comb begin
		d_est   = dprod_s3[DP_W-1:NUM_W];
		divisor = (cmd_s3 == DIR_TO_SRGB) ? SRGB_DIV : LIN_DIV;
		d_rem   = DREM_W'(numer_s3) - DREM_W'(DREM_W'(d_est) * DREM_W'(divisor));
		idx_nx  = idx_s3 + 1'b1;
		pt_a    = (cmd_s3 == DIR_TO_SRGB) ? srgb_tab[idx_s3] : lin_tab[idx_s3];
		pt_b    = (cmd_s3 == DIR_TO_SRGB) ? srgb_tab[idx_nx] : lin_tab[idx_nx];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			a_s4    <= pt_a;
			up_s4   <= pt_b >= pt_a;
			diff_s4 <= (pt_b >= pt_a) ? (pt_b - pt_a) : (pt_a - pt_b);
			frac_s4 <= frac_s3;
			knee_s4 <= knee_s3;
			liny_s4 <= d_est + RECIP_W'(d_rem >= DREM_W'(divisor));
		end
	end

	// stage 5: interpolate, pick branch, saturate to 1.0
	logic [IP_W-1:0] iprod;
	logic [Y_W-1:0]  step;
	logic [Y_W-1:0]  y_tab;
	logic [Y_W-1:0]  y_pick;
	logic [Y_W-1:0]  y_s5;

	always_comb begin
		iprod  = IP_W'(diff_s4) * IP_W'(frac_s4);
		step   = iprod[Y_W+Q_FRAC-1:Q_FRAC];
		y_tab  = up_s4 ? (a_s4 + step) : (a_s4 - step);
		y_pick = knee_s4 ? Y_W'(liny_s4) : y_tab;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			y_s5 <= (y_pick > Q_ONE) ? Q_ONE : y_pick;
		end
	end

	// stage 6: back to component scale, round half up
	logic [OW-1:0]   o_wide;
	logic [OQ_W-1:0] o_q;
	comp_t           conv_s6;

	always_comb begin
		o_wide = (OW'(y_s5) << COMPONENT_BITS) - OW'(y_s5) + (OW'(1) << (Q_FRAC - 1));
		o_q    = o_wide[OW-1:Q_FRAC];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			conv_s6 <= (o_q > OQ_W'(COMP_MAX)) ? COMP_MAX : o_q[COMPONENT_BITS-1:0];
		end
	end

	assign conv = conv_s6;

	a_x_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[1] |-> x_s2 <= Q_ONE)
		else $error("scaled component above 1.0");

	a_idx_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[2] |-> idx_s3 < IDX_W'(CURVE_SEGMENTS))
		else $error("segment index past last segment");

	a_y_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.vld[4] |-> y_s5 <= Q_ONE)
		else $error("curve output not saturated");

endmodule
`default_nettype wire

@@ rtl/srgb_linear_color_conversion_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srgb_linear_color_conversion_top - sRGB <-> linear RGBA pixel converter
// Streams RGBA pixels through the piecewise sRGB transfer function; alpha
// passes through. One pixel per clock while the result channel is not stalled.
// ----------------------------------------------------------------------------
// Usage: present one pixel per transaction on the pixel channel with cmd
// selecting the direction (DIR_TO_LINEAR or DIR_TO_SRGB). The block takes a
// new pixel every clock unless the result channel stalls, and returns each
// result once it has passed all six stages. The multipliers (full-scale
// reciprocal, curve position and branch divide, interpolation) spread over
// the stages set the depth; the throughput is one pixel per cycle when the
// result channel is not stalled. Every stage is an elastic register slice:
// a stalled result only stops stages that are full, so bubbles upstream
// keep filling and pixel_ready drops only when all six stages hold a pixel.
// Red, green and blue run in three identical lanes; the curve points
// (CURVE_SEGMENTS+1 per direction) are constants computed at elaboration,
// so there is no table load or clearing pass after reset.
// ----------------------------------------------------------------------------
module srgb_linear_color_conversion_top
	import srgb_lcc_pkg::*;
#(
	parameter int CURVE_SEGMENTS = CURVE_SEGMENTS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_ready,
	input  pixel_t  pixel,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// stage occupancy and per-stage advance
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	pipe_ctrl_t            ctrl;
	logic                  in_acc;
	logic                  out_acc;

	// a stage may load when empty or when the stage after it loads
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign ctrl.load    = en;
	assign ctrl.vld     = vld_q;
	assign pixel_ready  = en[0];
	assign result_valid = vld_q[NUM_STAGES-1];
	assign in_acc       = pixel_valid && pixel_ready;
	assign out_acc      = result_valid && result_ready;

	// advance valid bits; hold them where the stage is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= pixel_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// alpha rides alongside the lanes unchanged
	comp_t alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5, alpha_s6;

	always_ff @(posedge clk) begin
		if (en[0]) alpha_s1 <= pixel.alpha_in;
		if (en[1]) alpha_s2 <= alpha_s1;
		if (en[2]) alpha_s3 <= alpha_s2;
		if (en[3]) alpha_s4 <= alpha_s3;
		if (en[4]) alpha_s5 <= alpha_s4;
		if (en[5]) alpha_s6 <= alpha_s5;
	end

	// one lane per color component
	comp_t red_conv, green_conv, blue_conv;

	srgb_lcc_lane #(
		.CURVE_SEGMENTS(CURVE_SEGMENTS)
	) u_lane_red (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.cmd   (pixel.cmd),
		.comp  (pixel.red_in),
		.conv  (red_conv)
	);

	srgb_lcc_lane #(
		.CURVE_SEGMENTS(CURVE_SEGMENTS)
	) u_lane_green (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.cmd   (pixel.cmd),
		.comp  (pixel.green_in),
		.conv  (green_conv)
	);

	srgb_lcc_lane #(
		.CURVE_SEGMENTS(CURVE_SEGMENTS)
	) u_lane_blue (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.cmd   (pixel.cmd),
		.comp  (pixel.blue_in),
		.conv  (blue_conv)
	);

	always_comb begin
		result.red_out   = red_conv;
		result.green_out = green_conv;
		result.blue_out  = blue_conv;
		result.alpha_out = alpha_s6;
	end

	// pixels in flight change only by what enters and what leaves
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |->
			$countones(vld_q) == $past($countones(vld_q))
				+ int'($past(in_acc)) - int'($past(out_acc)))
		else $error("pipeline lost or duplicated a transaction");

	// back-pressure reaches the input only with every stage full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> &vld_q)
		else $error("input stalled while a stage is empty");

	// hold a stalled result steady until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed before its transaction");

endmodule
`default_nettype wire

@@ dv/tb_srgb_linear_color_conversion_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_srgb_linear_color_conversion_top - sRGB transfer function pixel test
// Streams RGBA pixels in both directions through the converter under random
// handshake pressure. A scoreboard predicts every result from its own
// fixed-point model of the piecewise curve, then checks each result field by
// field in order.
// ----------------------------------------------------------------------------

class srgb_pixel_scoreboard;

	localparam int SEGS     = srgb_lcc_pkg::CURVE_SEGMENTS_DEF;
	localparam int LOG_BITS = 20;
	localparam longint unsigned ONE      = 64'd1 << 30;
	localparam longint unsigned LIN_KNEE = 64'd43432857;
	localparam longint unsigned SRGB_KNEE = 64'd3361671;
	localparam longint unsigned OFFSET   = 64'd59055800;
	localparam longint unsigned SCALE    = ONE + OFFSET;
	localparam longint unsigned CMAX     = 64'd65535;

	longint unsigned to_lin_curve[0:SEGS];
	longint unsigned to_srgb_curve[0:SEGS];
	longint unsigned half_roots[0:LOG_BITS];
	srgb_lcc_pkg::result_t expected_results[$];
	int unsigned fail_count;

	function new();
		longint unsigned xi;
		longint unsigned t;
		longint unsigned s;
		fail_count = 0;
		half_roots[0] = 2 * ONE;
		for (int k = 1; k <= LOG_BITS; k++)
			half_roots[k] = int_sqrt(half_roots[k-1] << 30);
		for (int i = 0; i <= SEGS; i++) begin
			xi = (longint'(i) << 30) / SEGS;
			t = ((xi + OFFSET) << 30) / SCALE;
			to_lin_curve[i] = pow_q30(t, 12, 5);
			s = (pow_q30(xi, 5, 12) * SCALE) >> 30;
			to_srgb_curve[i] = (s > OFFSET) ? s - OFFSET : 64'd0;
		end
	endfunction

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v = v - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	// -log2(x) in Q20 for x in (0, 1] held as Q30
	function longint unsigned neg_log2_q20(longint unsigned x);
		longint unsigned whole;
		longint unsigned frac;
		longint unsigned m;
		whole = 0;
		frac = 0;
		m = x;
		while (m < ONE) begin
			m = m << 1;
			whole++;
		end
		for (int k = 1; k <= LOG_BITS; k++) begin
			m = (m * m) >> 30;
			if (m >= 2 * ONE) begin
				m = m >> 1;
				frac = frac | (64'd1 << (LOG_BITS - k));
			end
		end
		return (whole << LOG_BITS) - frac;
	endfunction

	// 2^(-l / 2^20) in Q30
	function longint unsigned exp2_neg_q30(longint unsigned l);
		longint unsigned n;
		longint unsigned f;
		longint unsigned g;
		longint unsigned r;
		n = l >> LOG_BITS;
		f = l & ((64'd1 << LOG_BITS) - 1);
		r = ONE;
		if (f == 0) return (n < 40) ? (ONE >> n) : 64'd0;
		g = (64'd1 << LOG_BITS) - f;
		for (int k = 1; k <= LOG_BITS; k++)
			if (((g >> (LOG_BITS - k)) & 64'd1) != 0) r = (r * half_roots[k]) >> 30;
		return ((n + 1) < 40) ? (r >> (n + 1)) : 64'd0;
	endfunction

	function longint unsigned pow_q30(longint unsigned x, longint unsigned num,
		longint unsigned den);
		longint unsigned l;
		if (x == 0) return 64'd0;
		if (x >= ONE) return ONE;
		l = (neg_log2_q20(x) * num + den / 2) / den;
		return exp2_neg_q30(l);
	endfunction

	function longint unsigned curve_lookup(bit to_srgb, longint unsigned x);
		longint unsigned pos;
		longint unsigned idx;
		longint unsigned frac;
		longint unsigned a;
		longint unsigned b;
		pos = x * SEGS;
		idx = pos >> 30;
		frac = pos & (ONE - 1);
		// full scale lands on the last segment at full weight
		if (idx >= SEGS) begin
			idx = SEGS - 1;
			frac = ONE;
		end
		a = to_srgb ? to_srgb_curve[idx] : to_lin_curve[idx];
		b = to_srgb ? to_srgb_curve[idx+1] : to_lin_curve[idx+1];
		if (b >= a) return a + (((b - a) * frac) >> 30);
		return a - (((a - b) * frac) >> 30);
	endfunction

	function srgb_lcc_pkg::comp_t convert_component(srgb_lcc_pkg::comp_t v, bit to_srgb);
		longint unsigned x;
		longint unsigned y;
		longint unsigned o;
		x = (longint'(v) << 30) / CMAX;
		if (!to_srgb)
			y = (x <= LIN_KNEE) ? (x * 100 + 646) / 1292 : curve_lookup(1'b0, x);
		else
			y = (x <= SRGB_KNEE) ? (x * 1292 + 50) / 100 : curve_lookup(1'b1, x);
		if (y > ONE) y = ONE;
		o = (y * CMAX + (ONE >> 1)) >> 30;
		if (o > CMAX) o = CMAX;
		return o[15:0];
	endfunction

	function void note_pixel(srgb_lcc_pkg::pixel_t p);
		srgb_lcc_pkg::result_t r;
		bit to_srgb;
		to_srgb = (p.cmd == srgb_lcc_pkg::DIR_TO_SRGB);
		r.red_out   = convert_component(p.red_in, to_srgb);
		r.green_out = convert_component(p.green_in, to_srgb);
		r.blue_out  = convert_component(p.blue_in, to_srgb);
		r.alpha_out = p.alpha_in;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function void compare_field(string field, srgb_lcc_pkg::comp_t want,
		srgb_lcc_pkg::comp_t got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
			fail_count++;
		end
	endfunction

	function void check_result(srgb_lcc_pkg::result_t got);
		srgb_lcc_pkg::result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result, expected none actual %h", $time, got);
			fail_count++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("red_out", want.red_out, got.red_out);
		compare_field("green_out", want.green_out, got.green_out);
		compare_field("blue_out", want.blue_out, got.blue_out);
		compare_field("alpha_out", want.alpha_out, got.alpha_out);
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

endclass

module tb_srgb_linear_color_conversion_top;
	import srgb_lcc_pkg::*;

	// pipeline is six stages deep; give the tail a comfortable margin
	localparam int DRAIN_CYCLES     = 32;
	localparam int ITEMS_PER_PHASE  = 250;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    pixel_valid  = 1'b0;
	logic    pixel_ready;
	pixel_t  pixel        = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// handshake pressure, in percent, changed per phase
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;

	srgb_pixel_scoreboard pix_sb;

	srgb_linear_color_conversion_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Present one pixel, hold it until the transaction completes, record it,
	// then idle for a random number of cycles. Ready is sampled right after the
	// edge, so it is the value the block presented at that edge.
	task automatic send_pixel(input pixel_t p);
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
		pix_sb.note_pixel(p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Bias components toward the regions where the curve is most fragile:
	// the knee of each direction, segment boundaries and both range ends.
	function automatic comp_t random_component(input logic to_srgb);
		int unsigned seg;
		case ($urandom_range(0, 9))
			5: begin
				return to_srgb ? comp_t'(198 + $urandom_range(0, 16))
					: comp_t'(2642 + $urandom_range(0, 16));
			end
			6: return comp_t'(16'hffff - $urandom_range(0, 15));
			7: return comp_t'($urandom_range(0, 15));
			8: begin
				seg = $urandom_range(1, 255);
				return comp_t'((seg * 65535) / 256 + $urandom_range(0, 2) - 1);
			end
			default: return comp_t'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p.cmd      = logic'($urandom_range(0, 1));
		p.red_in   = random_component(p.cmd);
		p.green_in = random_component(p.cmd);
		p.blue_in  = random_component(p.cmd);
		p.alpha_in = comp_t'($urandom_range(0, 65535));
		return p;
	endfunction

	// Directed corners in both directions: zero, full scale, both sides of
	// each knee, the first segment boundary and alternating bit patterns.
	task automatic run_directed();
		comp_t corner[6][4];
		pixel_t p;
		corner = '{
			'{16'd0, 16'd0, 16'd0, 16'd0},
			'{16'hffff, 16'hffff, 16'hffff, 16'hffff},
			'{16'd2650, 16'd2651, 16'd2652, 16'h8000},
			'{16'd205, 16'd206, 16'd1, 16'h00ff},
			'{16'h8000, 16'h00ff, 16'hff00, 16'h5a5a},
			'{16'h5555, 16'haaaa, 16'hfffe, 16'ha5a5}
		};
		foreach (corner[i]) begin
			for (int d = 0; d < 2; d++) begin
				p.cmd      = (d == 0) ? DIR_TO_LINEAR : DIR_TO_SRGB;
				p.red_in   = corner[i][0];
				p.green_in = corner[i][1];
				p.blue_in  = corner[i][2];
				p.alpha_in = corner[i][3];
				send_pixel(p);
			end
		end
	endtask

	// Result side: draw a fresh ready every cycle and check each completed
	// transaction against the oldest prediction.
	initial begin
		@(posedge arst_n);
		forever begin
			result_ready <= ($urandom_range(0, 99) >= stall_pct);
			@(posedge clk);
			if (result_valid && result_ready) pix_sb.check_result(result);
		end
	end

	initial begin
		pix_sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part runs with no pressure
		run_directed();

		// random part: free flow, sender gaps, receiver stalls, then both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 72; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 72; end
				default: begin send_idle_pct = 17; stall_pct = 17; end
			endcase
			repeat (ITEMS_PER_PHASE) send_pixel(random_pixel());
		end
		pixel_valid <= 1'b0;

		// drain: wait for every prediction, then watch for strays
		while (pix_sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pix_sb.fail_count == 0 && pix_sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

@@ files.f @@
rtl/srgb_lcc_pkg.sv
rtl/srgb_lcc_lane.sv
rtl/srgb_linear_color_conversion_top.sv
dv/tb_srgb_linear_color_conversion_top.sv
